@@ design/mciir_pkg.sv @@
package mciir_pkg;

    // Q1.15 sample and Q2.14 coefficient words
    typedef logic signed [15:0] sample_t;
    typedef logic signed [15:0] coef_word_t;

    localparam int SAMPLE_W   = 16;
    localparam int CH_W       = 3;
    localparam int CH_EXT_W   = 7;   // holds any channel count up to 127
    localparam int HIST_DEPTH = 3;
    localparam int ACC_W      = 36;  // seven Q3.29 products, exact
    localparam int FRAC_SHIFT = 14;
    localparam int ROUND_BIAS = 8192;
    localparam int TDATA_W    = 24;

    localparam int DEF_CHANNELS   = 8;
    localparam int DEF_NUM_B_TAPS = 4;
    localparam int DEF_NUM_A_TAPS = 4;

    localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAT_MIN = -16'sh8000;
    localparam logic signed [15:0] B0_RESET = 16'sh4000;

    typedef logic signed [ACC_W-1:0] acc_t;

    // Register map
    typedef enum logic [2:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_B3 = 3'd3,
        REG_A1 = 3'd4,
        REG_A2 = 3'd5,
        REG_A3 = 3'd6
    } reg_idx_t;

    // Item kinds carried in s_tuser
    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef struct packed {
        coef_word_t [3:0] b;   // b[k] = b_k
        coef_word_t [2:0] a;   // a[k] = a_(k+1)
    } coef_set_t;

    typedef struct packed {
        sample_t [HIST_DEPTH-1:0] x;   // x[0] is the newest input
        sample_t [HIST_DEPTH-1:0] y;   // y[0] is the newest output
    } hist_row_t;

endpackage

@@ design/mciir_cfg.sv @@
module mciir_cfg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output mciir_pkg::coef_set_t  coef
);
    import mciir_pkg::*;

    coef_set_t coef_reg;

    assign cfg_ready = 1'b1;
    assign coef      = coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.b <= {{3{16'h0000}}, B0_RESET};
            coef_reg.a <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_B0:  coef_reg.b[0] <= cfg_data;
                REG_B1:  coef_reg.b[1] <= cfg_data;
                REG_B2:  coef_reg.b[2] <= cfg_data;
                REG_B3:  coef_reg.b[3] <= cfg_data;
                REG_A1:  coef_reg.a[0] <= cfg_data;
                REG_A2:  coef_reg.a[1] <= cfg_data;
                REG_A3:  coef_reg.a[2] <= cfg_data;
                default: ;  // unmapped index, dropped
            endcase
        end
    end

endmodule

@@ design/mciir_hist.sv @@
module mciir_hist #(
    parameter int CHANNELS = mciir_pkg::DEF_CHANNELS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // read port, sampled when an item is taken into the stage register
    input  logic                  rd_en,
    input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] rd_idx,
    // write port, driven by the item leaving the stage register
    input  logic                  wr_en,
    input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] wr_idx,
    input  mciir_pkg::hist_row_t  wr_row,
    input  logic                  clr,
    output mciir_pkg::hist_row_t  rd_row
);
    import mciir_pkg::*;

    hist_row_t            mem [CHANNELS];
    logic [CHANNELS-1:0]  valid_reg;
    hist_row_t            mem_q_reg;
    hist_row_t            byp_row_reg;
    logic                 zero_reg;
    logic                 byp_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_row;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clr) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // A clear reads as zero; else the row being written this cycle wins over the stale memory copy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_reg <= 1'b1;
            byp_reg  <= 1'b0;
        end else if (rd_en) begin
            priority if (clr) begin
                zero_reg <= 1'b1;
                byp_reg  <= 1'b0;
            end else if (wr_en && wr_idx == rd_idx) begin
                zero_reg <= 1'b0;
                byp_reg  <= 1'b1;
            end else begin
                zero_reg <= !valid_reg[rd_idx];
                byp_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            byp_row_reg <= wr_row;
        end
    end

    always_comb begin
        priority if (zero_reg) begin
            rd_row = '0;
        end else if (byp_reg) begin
            rd_row = byp_row_reg;
        end else begin
            rd_row = mem_q_reg;
        end
    end

endmodule

@@ design/mciir_mac.sv @@
module mciir_mac #(
    parameter int NUM_B_TAPS = mciir_pkg::DEF_NUM_B_TAPS,
    parameter int NUM_A_TAPS = mciir_pkg::DEF_NUM_A_TAPS
) (
    input  mciir_pkg::coef_set_t  coef,
    input  mciir_pkg::sample_t    x_in,
    input  mciir_pkg::hist_row_t  row,
    output mciir_pkg::sample_t    y_out,
    output logic                  sat,
    output mciir_pkg::hist_row_t  row_next
);
    import mciir_pkg::*;

    logic signed [2*SAMPLE_W-1:0] prod_b [4];
    logic signed [2*SAMPLE_W-1:0] prod_a [3];
    acc_t                         acc;
    acc_t                         biased;
    logic signed [ACC_W-FRAC_SHIFT-1:0] y_wide;

    always_comb begin
        prod_b[0] = $signed(coef.b[0]) * $signed(x_in);
        for (int k = 1; k < 4; k++) begin
            prod_b[k] = $signed(coef.b[k]) * $signed(row.x[k-1]);
        end
        for (int k = 0; k < 3; k++) begin
            prod_a[k] = $signed(coef.a[k]) * $signed(row.y[k]);
        end

        acc = '0;
        for (int k = 0; k < 4; k++) begin
            if (k < NUM_B_TAPS) begin
                acc = acc + acc_t'(prod_b[k]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (k + 1 < NUM_A_TAPS) begin
                acc = acc - acc_t'(prod_a[k]);
            end
        end

        // round half up, drop 14 fraction bits
        biased = acc + acc_t'(ROUND_BIAS);
        y_wide = biased[ACC_W-1:FRAC_SHIFT];

        if (y_wide > (ACC_W-FRAC_SHIFT)'(SAT_MAX)) begin
            y_out = SAT_MAX;
            sat   = 1'b1;
        end else if (y_wide < (ACC_W-FRAC_SHIFT)'(SAT_MIN)) begin
            y_out = SAT_MIN;
            sat   = 1'b1;
        end else begin
            y_out = y_wide[SAMPLE_W-1:0];
            sat   = 1'b0;
        end

        row_next.x = {row.x[HIST_DEPTH-2:0], x_in};
        row_next.y = {row.y[HIST_DEPTH-2:0], y_out};
    end

endmodule

@@ design/multichannel_iir_filter_core.sv @@
// Channel   Dir  Handshake              Payload
// s_        in   s_tvalid / s_tready    tdata: channel, sample_in; tuser: func
// m_        out  m_tvalid / m_tready    tdata: sample_out, out_channel; tuser: saturated
// cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data (coefficient write)
//
// One item per cycle unless m_tready stalls; an accepted item passes the stage and result registers.
// The stage register feeds the multiply-accumulate and the result register
// directly, so a channel's new output is in its history before its next item.
// Reset (aresetn low, synchronous) restores coefficients and empties all
// channel histories at once through per-channel valid bits.
// A clear item or an item for a channel at or above CHANNELS gives no result.
// m_tready low stalls the stage only once an item with a result is waiting.
module multichannel_iir_filter_core #(
    parameter int CHANNELS   = mciir_pkg::DEF_CHANNELS,
    parameter int NUM_B_TAPS = mciir_pkg::DEF_NUM_B_TAPS,
    parameter int NUM_A_TAPS = mciir_pkg::DEF_NUM_A_TAPS
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [2:0] channel, [18:3] sample_in, rest zero
    input  logic [0:0]  s_tuser,    // [0] func

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [15:0] sample_out, [18:16] out_channel, rest zero
    output logic [0:0]  m_tuser,    // [0] saturated

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import mciir_pkg::*;

    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    coef_set_t           coef;

    // stage register
    logic                s1_valid_reg;
    logic                s1_func_reg;
    logic [CH_W-1:0]     s1_ch_reg;
    sample_t             s1_x_reg;

    // result register
    logic                m_valid_reg;
    sample_t             m_sample_reg;
    logic [CH_W-1:0]     m_ch_reg;
    logic                m_sat_reg;

    logic                s_accept;
    logic                s1_in_range;
    logic                s1_emit;
    logic                s1_adv;
    logic                s1_clear;
    logic                out_free;

    logic [CH_EXT_W-1:0] s_ch_ext;
    logic [CH_EXT_W-1:0] s1_ch_ext;

    hist_row_t           row;
    hist_row_t           row_next;
    sample_t             y;
    logic                y_sat;

    mciir_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // handshake and stage control
    assign out_free    = !m_valid_reg || m_tready;
    assign s1_ch_ext   = CH_EXT_W'(s1_ch_reg);
    assign s_ch_ext    = CH_EXT_W'(s_tdata[2:0]);
    assign s1_in_range = s1_ch_ext < CH_EXT_W'(CHANNELS);
    assign s1_emit     = (s1_func_reg == FUNC_FILTER) && s1_in_range;
    assign s1_clear    = s1_valid_reg && (s1_func_reg == FUNC_CLEAR);
    assign s1_adv      = s1_valid_reg && (!s1_emit || out_free);
    assign s_tready    = !s1_valid_reg || s1_adv;
    assign s_accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_func_reg <= s_tuser[0];
            s1_ch_reg   <= s_tdata[2:0];
            s1_x_reg    <= s_tdata[18:3];
        end
    end

    // per-channel history rows; read on accept, written as the item leaves
    mciir_hist #(
        .CHANNELS (CHANNELS)
    ) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_idx  (s_ch_ext[CH_AW-1:0]),
        .wr_en   (s1_adv && s1_emit),
        .wr_idx  (s1_ch_ext[CH_AW-1:0]),
        .wr_row  (row_next),
        .clr     (s1_adv && s1_clear),
        .rd_row  (row)
    );

    mciir_mac #(
        .NUM_B_TAPS (NUM_B_TAPS),
        .NUM_A_TAPS (NUM_A_TAPS)
    ) u_mac (
        .coef     (coef),
        .x_in     (s1_x_reg),
        .row      (row),
        .y_out    (y),
        .sat      (y_sat),
        .row_next (row_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_adv && s1_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_adv && s1_emit) begin
            m_sample_reg <= y;
            m_ch_reg     <= s1_ch_reg;
            m_sat_reg    <= y_sat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_ch_reg, m_sample_reg};
    assign m_tuser  = m_sat_reg;

`ifndef SYNTHESIS
    // a clipped result sits on a rail
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_sat_reg) |-> (m_sample_reg == SAT_MAX || m_sample_reg == SAT_MIN))
        else $error("saturation flag without rail value");

    // a filter item leaving the stage shows up as a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && s1_emit) |=> m_valid_reg)
        else $error("filtered item lost");

    // an item with no result never disturbs a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && !s1_emit && m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_sample_reg)))
        else $error("silent item disturbed pending result");

    // results only come out for channels that exist
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (CH_EXT_W'(m_ch_reg) < CH_EXT_W'(CHANNELS)))
        else $error("result for nonexistent channel");
`endif

endmodule

@@ dv/multichannel_iir_filter_core_test.sv @@
`timescale 1ns / 100ps

module multichannel_iir_filter_core_test;
    import mciir_pkg::*;

    localparam int NUM_CH          = DEF_CHANNELS;
    localparam int PIPE_SETTLE     = 4;        // margin for the stage and result registers
    localparam int HOLD_OFF_CYCLES = 60;       // long enough to fill the pipe
    localparam int ITEMS_PER_PHASE = 220;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;  // no register behind this index

    // One filtered sample as it should leave the m_ side
    typedef struct {
        sample_t    value;
        logic [2:0] ch;
        logic       sat;
    } filtered_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // [2:0] channel, [18:3] sample_in, rest zero
    logic [0:0]  s_tuser   = '0;   // [0] func
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // [15:0] sample_out, [18:16] out_channel, rest zero
    logic [0:0]  m_tuser;          // [0] saturated
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // Predictor state: coefficients and per-channel histories
    coef_word_t ff_coef [4];                 // b0..b3
    coef_word_t fb_coef [3];                 // a1..a3
    sample_t    x_hist  [NUM_CH][HIST_DEPTH];
    sample_t    y_hist  [NUM_CH][HIST_DEPTH];
    filtered_t  expected_samples [$];

    int errors     = 0;
    bit idle_on    = 1'b1;   // random gaps on both sides
    int hold_req   = 0;      // a test asks the receiver for a long hold-off
    int hold_left  = 0;
    int stall_left = 0;

    multichannel_iir_filter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_histories();
        foreach (x_hist[c, k]) begin
            x_hist[c][k] = '0;
            y_hist[c][k] = '0;
        end
    endfunction

    function automatic void load_reset_coefs();
        foreach (ff_coef[k]) ff_coef[k] = '0;
        foreach (fb_coef[k]) fb_coef[k] = '0;
        ff_coef[0] = B0_RESET;   // unity gain pass-through
    endfunction

    function automatic void apply_coef(logic [2:0] idx, logic [15:0] val);
        case (idx)
            REG_B0: ff_coef[0] = val;
            REG_B1: ff_coef[1] = val;
            REG_B2: ff_coef[2] = val;
            REG_B3: ff_coef[3] = val;
            REG_A1: fb_coef[0] = val;
            REG_A2: fb_coef[1] = val;
            REG_A3: fb_coef[2] = val;
            default: ;           // unmapped index, write dropped
        endcase
    endfunction

    // Direct-form-I step for one accepted item; queues the sample it yields
    function automatic void compute_filter_output(logic func, logic [2:0] ch, sample_t x);
        longint    acc;
        longint    y;
        filtered_t r;
        if (func == FUNC_CLEAR) begin
            clear_histories();
            return;
        end
        // Q1.15 x Q2.14 products summed exactly
        acc = longint'(ff_coef[0]) * longint'(x);
        for (int k = 1; k <= HIST_DEPTH; k++) begin
            acc += longint'(ff_coef[k]) * longint'(x_hist[ch][k-1]);
            acc -= longint'(fb_coef[k-1]) * longint'(y_hist[ch][k-1]);
        end
        // round half up, floor shift back to Q1.15
        y = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
        r.sat = 1'b0;
        if (y > longint'(SAT_MAX)) begin
            y     = longint'(SAT_MAX);
            r.sat = 1'b1;
        end else if (y < longint'(SAT_MIN)) begin
            y     = longint'(SAT_MIN);
            r.sat = 1'b1;
        end
        for (int k = HIST_DEPTH - 1; k >= 1; k--) begin
            x_hist[ch][k] = x_hist[ch][k-1];
            y_hist[ch][k] = y_hist[ch][k-1];
        end
        x_hist[ch][0] = x;
        y_hist[ch][0] = sample_t'(y);
        r.value = sample_t'(y);
        r.ch    = ch;
        expected_samples.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Drivers (change at the falling edge, handshake seen at the rising edge)
    // ------------------------------------------------------------------
    task automatic send_item(logic func, logic [2:0] ch, sample_t x);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, x, ch};
        s_tuser  = func;
        do @(posedge aclk); while (!s_tready);
        compute_filter_output(func, ch, x);
    endtask

    task automatic write_coef(logic [2:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        apply_coef(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Stop offering items and let every pending result come out. Clear items
    // give no result, so the extra cycles cover one still in the pipe.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    function automatic sample_t random_sample();
        case ($urandom_range(0, 7))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return sample_t'(int'($urandom_range(0, 64)) - 32);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_random_items(int n);
        logic func;
        for (int i = 0; i < n; i++) begin
            func = ($urandom_range(0, 63) == 0) ? FUNC_CLEAR : FUNC_FILTER;
            send_item(func, 3'($urandom_range(0, NUM_CH - 1)), random_sample());
        end
    endtask

    task automatic write_all_coefs(logic [15:0] val);
        reg_idx_t r;
        r = r.first();
        repeat (r.num()) begin
            write_coef(r, val);
            r = r.next();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset coefficients: b0 = 1.0, so every channel passes its input through
    task automatic test_unity_gain();
        sample_t vals [NUM_CH];
        vals = '{SAT_MAX, SAT_MIN, 16'sh0000, 16'sh0001,
                 -16'sh0001, 16'sh5555, -16'sh5556, 16'sh00FF};
        for (int c = 0; c < NUM_CH; c++)
            send_item(FUNC_FILTER, 3'(c), vals[c]);
        drain();
    endtask

    // Full-scale coefficients drive the sum into both saturation rails;
    // a write to the unmapped index must not disturb anything
    task automatic test_coef_extremes();
        write_all_coefs(16'h7FFF);
        write_coef(REG_UNMAPPED, 16'h1234);
        send_item(FUNC_FILTER, 3'd0, SAT_MAX);
        send_item(FUNC_FILTER, 3'd0, SAT_MAX);
        send_item(FUNC_FILTER, 3'd0, SAT_MIN);
        send_item(FUNC_FILTER, 3'd1, SAT_MIN);
        drain();
        write_all_coefs(16'h8000);
        send_item(FUNC_FILTER, 3'd2, SAT_MIN);
        send_item(FUNC_FILTER, 3'd2, SAT_MAX);
        send_item(FUNC_FILTER, 3'd2, SAT_MAX);
        drain();
    endtask

    // Build up history on channels 3 and 7, clear, then the taps must start from zero
    task automatic test_clear_history();
        write_coef(REG_B0, 16'h4000);
        write_coef(REG_B1, 16'h2000);
        write_coef(REG_B2, 16'hE000);
        write_coef(REG_B3, 16'h1000);
        write_coef(REG_A1, 16'hC000);
        write_coef(REG_A2, 16'h1000);
        write_coef(REG_A3, 16'hF000);
        send_item(FUNC_FILTER, 3'd3, 16'sh4000);
        send_item(FUNC_FILTER, 3'd3, -16'sh2000);
        send_item(FUNC_FILTER, 3'd3, 16'sh1234);
        send_item(FUNC_FILTER, 3'd7, 16'sh7000);
        send_item(FUNC_CLEAR, 3'd5, random_sample());
        send_item(FUNC_FILTER, 3'd3, 16'sh0100);
        send_item(FUNC_FILTER, 3'd7, 16'sh0100);
        drain();
    endtask

    // Several coefficient sets; odd phases keep the feedback small and stable
    task automatic test_random_phases();
        reg_idx_t r;
        for (int p = 0; p < 5; p++) begin
            r = r.first();
            repeat (r.num()) begin
                if (r >= REG_A1 && p[0])
                    write_coef(r, 16'(int'($urandom_range(0, 8191)) - 4096));
                else
                    write_coef(r, 16'($urandom));
                r = r.next();
            end
            send_random_items(ITEMS_PER_PHASE);
            drain();
        end
    endtask

    // Receiver holds off while items keep coming, so s_tready must drop
    task automatic test_output_backpressure();
        hold_req = HOLD_OFF_CYCLES;
        send_random_items(120);
        drain();
    endtask

    // Back-to-back traffic, no gaps on either side
    task automatic test_steady_stream();
        idle_on = 1'b0;
        send_random_items(150);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus the long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready   = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    // Result checker: each accepted item against the oldest expected sample
    always @(posedge aclk) begin
        filtered_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, actual tdata=%h tuser=%b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = expected_samples.pop_front();
                if (m_tdata[15:0] !== want.value) begin
                    errors++;
                    $display("%0t: sample_out expected %0d actual %0d", $time,
                             want.value, $signed(m_tdata[15:0]));
                end
                if (m_tdata[18:16] !== want.ch) begin
                    errors++;
                    $display("%0t: out_channel expected %0d actual %0d", $time,
                             want.ch, m_tdata[18:16]);
                end
                if (m_tuser[0] !== want.sat) begin
                    errors++;
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.sat, m_tuser[0]);
                end
                if (m_tdata[23:19] !== 5'b0) begin
                    errors++;
                    $display("%0t: tdata padding expected 0 actual %h", $time,
                             m_tdata[23:19]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        load_reset_coefs();
        clear_histories();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_unity_gain();
        test_coef_extremes();
        test_clear_history();
        test_random_phases();
        test_output_backpressure();
        test_steady_stream();

        if (errors == 0)
            $display("multichannel_iir_filter_core_test passed");
        else
            $display("multichannel_iir_filter_core_test failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("multichannel_iir_filter_core_test failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/mciir_pkg.sv
design/mciir_cfg.sv
design/mciir_hist.sv
design/mciir_mac.sv
design/multichannel_iir_filter_core.sv
dv/multichannel_iir_filter_core_test.sv
